FILE: rtl/core/jers_pkg.sv
// jers_pkg: shared constants, types and helpers for the edge reconstruction stencil
// used by jers_line_buf, jers_stencil and jacobi_edge_reconstruct_stencil
// no dependencies
package jers_pkg;

    localparam int MAX_ROW_LENGTH = 2048;
    localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_INDEX_W    = 2;
    localparam int ROW_W          = 12;
    localparam int VALUE_W        = 32;
    localparam int EDGE_W         = 16;
    localparam int SUM_W          = 35;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT  = 2'd1;

    typedef logic [COL_W-1:0] col_t;

    // one column of the line buffer: row one back, row two back, edges of row one back
    typedef struct packed {
        logic signed [VALUE_W-1:0] prev;
        logic signed [VALUE_W-1:0] older;
        logic signed [EDGE_W-1:0]  edg;
    } entry_t;

    typedef struct packed {
        col_t   rd_addr;
        logic   wr_en;
        col_t   wr_addr;
        entry_t wr_data;
        logic   head_load;
    } lb_req_t;

    // last column index for a row length write, clamped to 1..MAX_ROW_LENGTH
    function automatic col_t last_col_of(input logic [CFG_DATA_W-1:0] d);
        logic [31:0] v;
        v = {{(32-CFG_DATA_W){1'b0}}, d};
        if (v == 32'd0) begin
            v = 32'd1;
        end
        if (v > 32'(MAX_ROW_LENGTH)) begin
            v = 32'(MAX_ROW_LENGTH);
        end
        v = v - 32'd1;
        return v[COL_W-1:0];
    endfunction

endpackage

FILE: rtl/core/jers_line_buf.sv
// jers_line_buf: column line buffer memory with a two-entry read-ahead window
// head is the entry of the current column, look the entry of the next column
// depends on jers_pkg
module jers_line_buf
    import jers_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  lb_req_t req,
    output entry_t  head,
    output entry_t  look
);

    entry_t mem [MAX_ROW_LENGTH];
    entry_t rd_reg;
    entry_t byp_data_reg;
    logic   byp_reg;
    col_t   look_addr_reg;
    entry_t head_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_reg <= mem[req.rd_addr];
    end

    // read during write to the same column returns the new entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else begin
            byp_reg <= req.wr_en && (req.wr_addr == req.rd_addr);
        end
        byp_data_reg  <= req.wr_data;
        look_addr_reg <= req.rd_addr;
    end

    assign look = byp_reg ? byp_data_reg : rd_reg;

    always_ff @(posedge aclk) begin
        if (req.head_load) begin
            if (req.wr_en && (req.wr_addr == look_addr_reg)) begin
                head_reg <= req.wr_data;
            end else begin
                head_reg <= look;
            end
        end
    end

    assign head = head_reg;

endmodule

FILE: rtl/core/jers_stencil.sv
// jers_stencil: four-point sum minus scaled edge, divided by four, saturated
// depends on jers_pkg
module jers_stencil
    import jers_pkg::*;
(
    input  logic signed [VALUE_W-1:0] left_v,
    input  logic signed [VALUE_W-1:0] right_v,
    input  logic signed [VALUE_W-1:0] up_v,
    input  logic signed [VALUE_W-1:0] down_v,
    input  logic signed [EDGE_W-1:0]  edge_v,
    output logic signed [VALUE_W-1:0] result
);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] quot;
    logic signed [SUM_W-1:0] edge_q;

    always_comb begin
        // edge is an integer, scale to q23.8
        edge_q = SUM_W'($signed({edge_v, 8'b0}));
        sum = SUM_W'(left_v) + SUM_W'(right_v) + SUM_W'(up_v) + SUM_W'(down_v) - edge_q;
        quot = sum >>> 2;
        if (quot[SUM_W-1:VALUE_W-1] == '0 || quot[SUM_W-1:VALUE_W-1] == '1) begin
            result = quot[VALUE_W-1:0];
        end else if (quot[SUM_W-1]) begin
            result = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

endmodule

FILE: rtl/core/jacobi_edge_reconstruct_stencil.sv
// jacobi_edge_reconstruct_stencil: top level, sequencing, config and result buffering
// depends on jers_pkg, jers_line_buf, jers_stencil
//
// Usage: pixel items (op = pixel) stream in raster order on the s_ channel; each
// gives the updated pixel of the row above on the m_ channel, so results run one
// row behind. After the last row, one drain item per column emits the final row;
// the last one carries end_of_image and starts the next image. Pixel items while
// draining and drain items otherwise are taken and dropped.
// Throughput: one item per cycle while s_ready is high; the line buffer reads one
// column ahead so each memory sees one read and one write per cycle. A result is
// registered in the output register, or in the skid entry while m_ is stalled.
// Stalls: an output register plus one skid entry; s_ready drops while both
// are full.
// cfg_ writes (row_length, row_count) are taken in any cycle, restart the image
// and keep the line buffer contents. After reset or a write, s_ready stays low
// in FILL_READ0 and FILL_READ1 while the read-ahead window refills. The line
// buffer needs no clearing pass: every column is written in the first row before use.
module jacobi_edge_reconstruct_stencil
    import jers_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic signed [VALUE_W-1:0]     s_pixel_value,
    input  logic signed [EDGE_W-1:0]      s_edge_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_W-1:0]     m_new_value,
    output logic                          m_end_of_image,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam logic [1:0] FILL_READ0 = 2'd0;
    localparam logic [1:0] FILL_READ1 = 2'd1;
    localparam logic [1:0] FILL_RUN   = 2'd2;

    logic [1:0]                fill_reg;
    col_t                      last_col_reg;
    logic [ROW_W-1:0]          rows_reg;
    col_t                      col_reg;
    logic [ROW_W-1:0]          row_reg;
    logic                      draining_reg;
    logic signed [VALUE_W-1:0] left_reg;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_eoi_reg;
    logic                      skid_valid_reg;
    logic signed [VALUE_W-1:0] skid_value_reg;
    logic                      skid_eoi_reg;

    lb_req_t                   lb_req;
    entry_t                    head;
    entry_t                    look;

    logic                      accept;
    logic                      cfg_write;
    logic                      is_pixel;
    logic                      advance;
    logic                      produce;
    logic                      at_last;
    col_t                      col_next;
    col_t                      col_next2;
    logic [ROW_W:0]            row_inc;
    logic signed [VALUE_W-1:0] left_v;
    logic signed [VALUE_W-1:0] right_v;
    logic signed [VALUE_W-1:0] up_v;
    logic signed [VALUE_W-1:0] down_v;
    logic signed [VALUE_W-1:0] new_value;
    logic                      new_eoi;
    logic                      out_free;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid &&
                       (cfg_index == CFG_ROW_LENGTH || cfg_index == CFG_ROW_COUNT);

    assign s_ready = (fill_reg == FILL_RUN) && !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_pixel  = (s_op == OP_PIXEL);
        advance   = is_pixel ? !draining_reg : draining_reg;
        produce   = is_pixel ? (!draining_reg && row_reg != '0) : draining_reg;
        at_last   = (col_reg == last_col_reg);
        col_next  = at_last ? '0 : col_reg + 1'b1;
        col_next2 = (col_next == last_col_reg) ? '0 : col_next + 1'b1;
        row_inc   = {1'b0, row_reg} + 1'b1;

        left_v  = (col_reg == '0) ? '0 : left_reg;
        right_v = at_last ? '0 : look.prev;
        if (is_pixel) begin
            up_v   = (row_reg == ROW_W'(1)) ? '0 : head.older;
            down_v = s_pixel_value;
        end else begin
            up_v   = (rows_reg == ROW_W'(1)) ? '0 : head.older;
            down_v = '0;
        end
        new_eoi = !is_pixel && at_last;
    end

    // read-ahead window sequencing
    always_comb begin
        lb_req.wr_en          = accept && is_pixel && advance;
        lb_req.wr_addr        = col_reg;
        lb_req.wr_data.prev   = s_pixel_value;
        lb_req.wr_data.older  = head.prev;
        lb_req.wr_data.edg    = s_edge_value;
        lb_req.head_load      = 1'b0;
        case (fill_reg)
            FILL_READ0: begin
                lb_req.rd_addr = '0;
            end
            FILL_READ1: begin
                lb_req.rd_addr   = col_next;
                lb_req.head_load = 1'b1;
            end
            default: begin
                lb_req.head_load = accept && advance;
                lb_req.rd_addr   = (accept && advance) ? col_next2 : col_next;
            end
        endcase
    end

    jers_line_buf u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lb_req),
        .head    (head),
        .look    (look)
    );

    jers_stencil u_stencil (
        .left_v  (left_v),
        .right_v (right_v),
        .up_v    (up_v),
        .down_v  (down_v),
        .edge_v  (head.edg),
        .result  (new_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= FILL_READ0;
            last_col_reg <= last_col_of(CFG_DATA_W'(2048));
            rows_reg     <= ROW_W'(2048);
            col_reg      <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
        end else if (cfg_write) begin
            if (cfg_index == CFG_ROW_LENGTH) begin
                last_col_reg <= last_col_of(cfg_data);
            end else begin
                rows_reg <= (cfg_data == '0) ? ROW_W'(1) : ROW_W'(cfg_data);
            end
            fill_reg     <= FILL_READ0;
            col_reg      <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
        end else begin
            case (fill_reg)
                FILL_READ0: fill_reg <= FILL_READ1;
                FILL_READ1: fill_reg <= FILL_RUN;
                default:    fill_reg <= FILL_RUN;
            endcase
            if (accept && advance) begin
                col_reg <= col_next;
                if (at_last) begin
                    if (is_pixel) begin
                        if (row_inc >= {1'b0, rows_reg}) begin
                            row_reg      <= '0;
                            draining_reg <= 1'b1;
                        end else begin
                            row_reg <= row_inc[ROW_W-1:0];
                        end
                    end else begin
                        draining_reg <= 1'b0;
                        row_reg      <= '0;
                    end
                end
            end
        end
    end

    // left neighbor is masked at column zero, so no clear is needed
    always_ff @(posedge aclk) begin
        if (accept && advance) begin
            left_reg <= head.prev;
        end
    end

    // output register with one skid entry
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept && produce;
            end
        end else if (accept && produce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_value_reg <= skid_value_reg;
                out_eoi_reg   <= skid_eoi_reg;
            end else begin
                out_value_reg <= new_value;
                out_eoi_reg   <= new_eoi;
            end
        end else if (accept && produce) begin
            skid_value_reg <= new_value;
            skid_eoi_reg   <= new_eoi;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_new_value    = out_value_reg;
    assign m_end_of_image = out_eoi_reg;

endmodule

FILE: dv/tb_jacobi_edge_reconstruct_stencil.sv
// tb_jacobi_edge_reconstruct_stencil: self-checking testbench for the edge reconstruction stencil
// streams images in raster order and checks every updated pixel against its own line-buffer model
// depends on jers_pkg and jacobi_edge_reconstruct_stencil
module tb_jacobi_edge_reconstruct_stencil;
    import jers_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic signed [VALUE_W-1:0] PIX_MAX  = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] PIX_MIN  = 32'sh8000_0000;
    localparam logic signed [EDGE_W-1:0]  EDGE_MAX = 16'sh7fff;
    localparam logic signed [EDGE_W-1:0]  EDGE_MIN = 16'sh8000;

    localparam int RANDOM_ITEMS = 1350;

    typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_HIGH, FILL_LOW} fill_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      closing;
    } pixel_result_t;

    class reconstruct_checker;
        logic signed [VALUE_W-1:0] older_row [MAX_ROW_LENGTH];
        logic signed [VALUE_W-1:0] prev_row  [MAX_ROW_LENGTH];
        logic signed [EDGE_W-1:0]  prev_edge [MAX_ROW_LENGTH];
        int unsigned               col;
        int unsigned               row;
        bit                        draining;
        logic signed [VALUE_W-1:0] left_hold;
        logic [CFG_DATA_W-1:0]     len_reg;
        logic [CFG_DATA_W-1:0]     rows_reg;
        pixel_result_t             awaited[$];
        int                        errors;

        function new();
            for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
                older_row[i] = '0;
                prev_row[i]  = '0;
                prev_edge[i] = '0;
            end
            len_reg  = 12'd2048;
            rows_reg = 12'd2048;
            errors   = 0;
            restart_image();
        endfunction

        function void restart_image();
            col       = 0;
            row       = 0;
            draining  = 1'b0;
            left_hold = '0;
        endfunction

        function int unsigned span();
            if (len_reg == 0) return 1;
            if (len_reg > MAX_ROW_LENGTH) return MAX_ROW_LENGTH;
            return len_reg;
        endfunction

        function int unsigned depth();
            return (rows_reg == 0) ? 1 : rows_reg;
        endfunction

        function int awaiting();
            return awaited.size();
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 200) $display("MISMATCH at %0t: %s", $time, what);
        endfunction

        // (left + right + up + down - edge * 256) >>> 2, saturated to 32 bits
        function logic signed [VALUE_W-1:0] quarter_sum(input logic signed [VALUE_W-1:0] l, r, u, d,
                                                        input logic signed [EDGE_W-1:0] e);
            longint s;
            s = longint'(l) + longint'(r) + longint'(u) + longint'(d) - longint'(e) * 256;
            s = s >>> 2;
            if (s > 64'sh7fff_ffff) s = 64'sh7fff_ffff;
            if (s < -64'sh8000_0000) s = -64'sh8000_0000;
            return s[VALUE_W-1:0];
        endfunction

        function void note_write(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ROW_LENGTH) begin
                len_reg = data;
            end else if (idx == CFG_ROW_COUNT) begin
                rows_reg = data;
            end else begin
                return;
            end
            restart_image();
        endfunction

        function void note_item(input logic op, input logic signed [VALUE_W-1:0] pix,
                                input logic signed [EDGE_W-1:0] edg);
            int unsigned               len;
            int unsigned               rows;
            int unsigned               c;
            logic signed [VALUE_W-1:0] left;
            logic signed [VALUE_W-1:0] right;
            logic signed [VALUE_W-1:0] up;
            logic signed [VALUE_W-1:0] cur;
            pixel_result_t             res;
            len  = span();
            rows = depth();
            c    = col;
            if (c >= len) c = len - 1;
            left  = (c == 0) ? '0 : left_hold;
            right = (c + 1 < len) ? prev_row[c + 1] : '0;
            cur   = prev_row[c];
            if (op == OP_PIXEL) begin
                if (draining) return;
                if (row >= 1) begin
                    up          = (row == 1) ? '0 : older_row[c];
                    res.value   = quarter_sum(left, right, up, pix, prev_edge[c]);
                    res.closing = 1'b0;
                    awaited.push_back(res);
                end
                left_hold    = cur;
                older_row[c] = cur;
                prev_row[c]  = pix;
                prev_edge[c] = edg;
                col          = c + 1;
                if (col >= len) begin
                    col       = 0;
                    left_hold = '0;
                    row++;
                    if (row >= rows) begin
                        row      = 0;
                        draining = 1'b1;
                    end
                end
            end else if (draining) begin
                // final row: nothing below it
                up          = (rows == 1) ? '0 : older_row[c];
                res.value   = quarter_sum(left, right, up, '0, prev_edge[c]);
                res.closing = 1'b0;
                left_hold   = cur;
                col         = c + 1;
                if (col >= len) begin
                    res.closing = 1'b1;
                    restart_image();
                end
                awaited.push_back(res);
            end
        endfunction

        function void check_result(input logic signed [VALUE_W-1:0] value, input logic closing);
            pixel_result_t want;
            if (awaited.size() == 0) begin
                report($sformatf("result with nothing pending: new_value %0d end_of_image %b",
                                 value, closing));
                return;
            end
            want = awaited.pop_front();
            if (value !== want.value)
                report($sformatf("new_value %0d, expected %0d", value, want.value));
            if (closing !== want.closing)
                report($sformatf("end_of_image %b, expected %b", closing, want.closing));
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_op;
    logic signed [VALUE_W-1:0]  s_pixel_value;
    logic signed [EDGE_W-1:0]   s_edge_value;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [VALUE_W-1:0]  m_new_value;
    logic                       m_end_of_image;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    reconstruct_checker sb = new();

    bit sender_calm = 1'b0;
    bit hold_output = 1'b0;
    int scored_items = 0;

    jacobi_edge_reconstruct_stencil DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_pixel_value  (s_pixel_value),
        .s_edge_value   (s_edge_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_new_value    (m_new_value),
        .m_end_of_image (m_end_of_image),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // results before new items: a result always belongs to an earlier item
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_new_value, m_end_of_image);
            if (cfg_valid && cfg_ready) sb.note_write(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_item(s_op, s_pixel_value, s_edge_value);
        end
    end

    // mostly no gap, some short ones, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 15);
        if (r < 9) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_pixel(input fill_t mode);
        case (mode)
            FILL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return PIX_MAX;
                    1: return PIX_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            FILL_HIGH: return PIX_MAX - $urandom_range(0, 255);
            FILL_LOW: return PIX_MIN + $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // a negative edge pushes the sum up, a positive one pulls it down
    function automatic logic signed [EDGE_W-1:0] pick_edge(input fill_t mode);
        case (mode)
            FILL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return EDGE_MAX;
                    1: return EDGE_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            FILL_HIGH: return EDGE_MIN + EDGE_W'($urandom_range(0, 15));
            FILL_LOW: return EDGE_MAX - EDGE_W'($urandom_range(0, 15));
            default: return EDGE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] pix,
                             input logic signed [EDGE_W-1:0] edg);
        int gap;
        gap = sender_calm ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_op          <= op;
        s_pixel_value <= pix;
        s_edge_value  <= edg;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    // drop s_valid and let every pending pixel come out, then wait for items with no result
    task automatic settle_block();
        @(negedge aclk) s_valid <= 1'b0;
        while (sb.awaiting() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // one image in raster order then its drain items; cut < 0 runs it to the end
    task automatic run_image(input int cut, input fill_t mode, input bit noisy, input bit press);
        int len;
        int rows;
        int pixels;
        int total;
        int k;
        len    = sb.span();
        rows   = sb.depth();
        pixels = len * rows;
        total  = pixels + len;
        if (cut < 0 || cut > total) cut = total;
        sender_calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < cut; k++) begin
            if (press && k == pixels) hold_output = 1'b1;
            // stray item of the wrong kind, dropped by the block
            if (noisy && $urandom_range(0, 19) == 0)
                send_item((k < pixels) ? OP_DRAIN : OP_PIXEL, $urandom, EDGE_W'($urandom));
            if (k < pixels) begin
                send_item(OP_PIXEL, pick_pixel(mode), pick_edge(mode));
            end else begin
                send_item(OP_DRAIN, $urandom, EDGE_W'($urandom));
            end
            scored_items++;
        end
    endtask

    initial begin : result_sink
        int stall_left;
        int stretch;
        bit steady;
        stall_left = 0;
        stretch    = 0;
        steady     = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stretch == 0) begin
                stretch = $urandom_range(100, 400);
                steady  = ($urandom_range(0, 3) == 0);
            end
            stretch--;
            if (hold_output) begin
                hold_output = 1'b0;
                stall_left  = 400;
            end
            if (stall_left == 0 && !steady) stall_left = idle_len();
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] len_data;
        logic [CFG_DATA_W-1:0] rows_data;
        int                    which;
        int                    images;
        int                    cut;
        int                    waited;
        fill_t                 mode;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = OP_PIXEL;
        s_pixel_value = '0;
        s_edge_value  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_ROW_LENGTH;
        cfg_data      = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // 3x3 image with extreme values, plus items that arrive at the wrong moment
        write_reg(CFG_ROW_LENGTH, 12'd3);
        write_reg(CFG_ROW_COUNT, 12'd3);
        send_item(OP_DRAIN, PIX_MAX, EDGE_MAX);
        send_item(OP_PIXEL, PIX_MAX, EDGE_MIN);
        send_item(OP_PIXEL, PIX_MIN, EDGE_MAX);
        send_item(OP_PIXEL, '0, '0);
        send_item(OP_PIXEL, PIX_MAX, EDGE_MIN);
        send_item(OP_PIXEL, PIX_MAX, EDGE_MIN);
        send_item(OP_PIXEL, PIX_MAX, EDGE_MIN);
        send_item(OP_PIXEL, PIX_MIN, EDGE_MAX);
        send_item(OP_PIXEL, PIX_MIN, EDGE_MAX);
        send_item(OP_PIXEL, '1, '1);
        send_item(OP_PIXEL, PIX_MAX, EDGE_MAX);
        send_item(OP_DRAIN, '0, '0);
        send_item(OP_DRAIN, '1, '1);
        send_item(OP_DRAIN, PIX_MIN, EDGE_MIN);

        // zero registers count as a single pixel image
        settle_block();
        write_reg(CFG_ROW_LENGTH, 12'd0);
        write_reg(CFG_ROW_COUNT, 12'd0);
        send_item(OP_PIXEL, PIX_MAX, EDGE_MIN);
        send_item(OP_DRAIN, '0, '0);
        settle_block();
        write_reg(CFG_SPARE_LO, 12'hfff);
        write_reg(CFG_SPARE_HI, 12'h000);

        // output held off while drains keep coming, so the block fills and stalls
        write_reg(CFG_ROW_LENGTH, 12'd8);
        write_reg(CFG_ROW_COUNT, 12'd3);
        run_image(-1, FILL_EXTREME, 1'b0, 1'b1);

        // single column, row count beyond the usual range, abandoned partway
        settle_block();
        write_reg(CFG_ROW_LENGTH, 12'd1);
        write_reg(CFG_ROW_COUNT, 12'hfff);
        run_image(100, FILL_RANDOM, 1'b1, 1'b0);

        scored_items = 0;
        while (scored_items < RANDOM_ITEMS) begin
            settle_block();
            case ($urandom_range(0, 9))
                0: len_data = 12'd0;
                1: len_data = 12'd1;
                2: len_data = 12'd2;
                default: len_data = 12'($urandom_range(3, 10));
            endcase
            case ($urandom_range(0, 7))
                0: rows_data = 12'd0;
                1: rows_data = 12'd1;
                default: rows_data = 12'($urandom_range(2, 6));
            endcase
            which = $urandom_range(0, 3);
            if (which != 1) write_reg(CFG_ROW_LENGTH, len_data);
            if (which != 0) write_reg(CFG_ROW_COUNT, rows_data);
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 12'($urandom));
            images = $urandom_range(1, 3);
            for (int i = 0; i < images; i++) begin
                mode = $urandom_range(0, 1) ? FILL_RANDOM : fill_t'($urandom_range(1, 3));
                // now and then abandon the last image partway through
                cut = -1;
                if (i == images - 1 && $urandom_range(0, 4) == 0)
                    cut = $urandom_range(0, sb.span() * (sb.depth() + 1) - 1);
                run_image(cut, mode, 1'b1, 1'b0);
            end
        end

        @(negedge aclk) s_valid <= 1'b0;
        waited = 0;
        while (sb.awaiting() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (sb.awaiting() != 0)
            sb.report($sformatf("%0d expected results never came out", sb.awaiting()));
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // about fifteen hundred items; even with every gap and stall at its longest this is far off
    initial begin
        #50_000_000;
        $display("timeout: the run did not complete");
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/jers_pkg.sv
rtl/core/jers_line_buf.sv
rtl/core/jers_stencil.sv
rtl/core/jacobi_edge_reconstruct_stencil.sv
dv/tb_jacobi_edge_reconstruct_stencil.sv
